// ===== sv/ffca_pkg.sv =====
// Shared constants for the first-fit capacity allocator.
// No dependencies; compiled before the interfaces and the top level.
package ffca_pkg;

	localparam int AMOUNT_W      = 30;    // capacity and request width
	localparam int MAX_BINS_DEF  = 1024;  // default table size

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

endpackage

// ===== sv/ffca_if.sv =====
// Valid/ready channel interfaces for the first-fit capacity allocator.
// Depends on ffca_pkg for the amount width.
interface ffca_item_if;
	import ffca_pkg::*;

	logic                valid;
	logic                ready;
	logic                func;
	logic [AMOUNT_W-1:0] amount;

	modport source (output valid, output func, output amount, input ready);
	modport sink   (input valid, input func, input amount, output ready);
endinterface

interface ffca_result_if #(
	parameter int BIN_W = 11
);
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] bin_number;

	modport source (output valid, output bin_number, input ready);
	modport sink   (input valid, input bin_number, output ready);
endinterface

// ===== sv/first_fit_capacity_allocator.sv =====
// First-fit capacity allocator: max tree over a bin table held in one RAM.
// Depends on ffca_pkg and the channel interfaces in ffca_if.sv.

// After reset the block clears its tree RAM, one entry a cycle, over all
// 4*MAX_BINS nodes and takes no beat meanwhile. A load beat (func 0)
// appends one bin capacity and returns no result: after the accept it
// walks down by bin position one level at a time to the leaf, writes it,
// then rewrites the maxima level by level on the way up. Loads beyond
// MAX_BINS bins are dropped. A request beat (func 1) returns the 1-based
// number of the lowest bin whose remaining capacity covers the request,
// or 0. The walk down and back up is serial because the tree RAM has
// one read port: every level costs one dependent read on the way down
// and one read-modify-write on the way up. A request that fits nowhere
// is rejected at the root, and a zero request goes straight to the
// output stage; neither descends the tree. Items are taken one at a
// time; a finished result waits in an output register and the next
// item is accepted while it waits.
module first_fit_capacity_allocator #(
	parameter int MAX_BINS = ffca_pkg::MAX_BINS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ffca_item_if.sink            item,
	ffca_result_if.source        result
);
	import ffca_pkg::*;

	localparam int IW    = $clog2(MAX_BINS);       // bin index width
	localparam int BW    = $clog2(MAX_BINS + 1);   // bin count / number width
	localparam int NODES = 4 * MAX_BINS;           // tree nodes, root is 1
	localparam int NW    = $clog2(NODES);          // node address width

	typedef enum logic [2:0] {
		S_CLEAR,   // zeroing the tree RAM after reset
		S_IDLE,    // waiting for a beat
		S_ROOT,    // root max arrives, reject if too small
		S_DESC,    // request descent, left child max arrives
		S_LEAF,    // leaf value arrives, subtract request
		S_LDESC,   // load descent by bin position
		S_UP,      // sibling arrives, rewrite parent max
		S_PUSH     // hand result to output register
	} state_t;

	state_t              state_q;
	logic [NW-1:0]       clr_q;
	logic [BW-1:0]       loaded_q;
	logic                is_req_q;
	logic [NW-1:0]       node_q;
	logic [IW-1:0]       s_q;
	logic [IW-1:0]       e_q;
	logic [IW-1:0]       pos_q;
	logic [AMOUNT_W-1:0] want_q;
	logic [AMOUNT_W-1:0] cur_q;
	logic [BW-1:0]       res_q;
	logic                out_valid_q;
	logic [BW-1:0]       out_bin_q;

	// tree RAM, one write and one registered read per cycle
	logic [AMOUNT_W-1:0] tree_mem [NODES];
	logic [AMOUNT_W-1:0] rdata;
	logic                mem_we;
	logic [NW-1:0]       mem_wa;
	logic [AMOUNT_W-1:0] mem_wd;
	logic [NW-1:0]       mem_ra;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[mem_wa] <= mem_wd;
		end
		rdata <= tree_mem[mem_ra];
	end

	// descent step shared by loads and requests
	logic                accept;
	logic                push;
	logic [IW-1:0]       mid;
	logic                go_left;
	logic [NW-1:0]       nxt_node;
	logic [IW-1:0]       nxt_s;
	logic [IW-1:0]       nxt_e;
	logic                nxt_leaf;
	logic [NW-1:0]       par;
	logic [AMOUNT_W-1:0] cur_max;
	logic [AMOUNT_W-1:0] leaf_val;

	assign accept   = item.valid && item.ready;
	// result moves into the output register when it is free or draining
	assign push     = (state_q == S_PUSH) && (!out_valid_q || result.ready);
	assign mid      = s_q + ((e_q - s_q) >> 1);
	// loads steer by position; requests by the left child max just read
	assign go_left  = (state_q == S_LDESC) ? (pos_q <= mid) : (rdata >= want_q);
	assign nxt_node = {node_q[NW-2:0], ~go_left};
	assign nxt_s    = go_left ? s_q : mid + IW'(1);
	assign nxt_e    = go_left ? mid : e_q;
	assign nxt_leaf = (nxt_s == nxt_e);
	assign par      = node_q >> 1;
	assign cur_max  = (rdata > cur_q) ? rdata : cur_q;
	assign leaf_val = rdata - want_q;

	// RAM port control; the write and the read of one cycle share an address only
	// while clearing node 0, whose read data is unused, so no forwarding is needed
	always_comb begin
		mem_we = 1'b0;
		mem_wa = node_q;
		mem_wd = cur_q;
		mem_ra = node_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			S_IDLE: begin
				mem_ra = NW'(1);
			end
			S_ROOT: begin
				mem_ra = {node_q[NW-2:0], 1'b0};
			end
			S_DESC: begin
				mem_ra = nxt_leaf ? nxt_node : {nxt_node[NW-2:0], 1'b0};
			end
			S_LEAF: begin
				mem_we = 1'b1;
				mem_wa = node_q;
				mem_wd = leaf_val;
				mem_ra = node_q ^ NW'(1);
			end
			S_LDESC: begin
				mem_we = (s_q == e_q);
				mem_wa = node_q;
				mem_wd = cur_q;
				mem_ra = node_q ^ NW'(1);
			end
			S_UP: begin
				mem_we = 1'b1;
				mem_wa = par;
				mem_wd = cur_max;
				mem_ra = par ^ NW'(1);
			end
			S_PUSH: begin
				mem_ra = node_q;
			end
			default: begin
				mem_ra = node_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			loaded_q    <= '0;
			is_req_q    <= 1'b0;
			node_q      <= '0;
			s_q         <= '0;
			e_q         <= '0;
			pos_q       <= '0;
			want_q      <= '0;
			cur_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_bin_q   <= '0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						node_q   <= NW'(1);
						s_q      <= '0;
						e_q      <= IW'(MAX_BINS - 1);
						is_req_q <= (item.func == FUNC_REQUEST);
						if (item.func == FUNC_LOAD) begin
							// full table: drop the load
							if (loaded_q != BW'(MAX_BINS)) begin
								loaded_q <= loaded_q + BW'(1);
								pos_q    <= loaded_q[IW-1:0];
								cur_q    <= item.amount;
								state_q  <= S_LDESC;
							end
						end else begin
							want_q <= item.amount;
							if (item.amount == '0) begin
								// zero request fits bin 1 once anything is loaded
								res_q   <= (loaded_q != '0) ? BW'(1) : BW'(0);
								state_q <= S_PUSH;
							end else begin
								state_q <= S_ROOT;
							end
						end
					end
				end
				S_ROOT: begin
					if (rdata < want_q) begin
						res_q   <= '0;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_DESC;
					end
				end
				S_DESC: begin
					node_q <= nxt_node;
					s_q    <= nxt_s;
					e_q    <= nxt_e;
					if (nxt_leaf) begin
						state_q <= S_LEAF;
					end
				end
				S_LEAF: begin
					cur_q   <= leaf_val;
					res_q   <= BW'(s_q) + BW'(1);
					state_q <= S_UP;
				end
				S_LDESC: begin
					if (s_q == e_q) begin
						state_q <= S_UP;
					end else begin
						node_q <= nxt_node;
						s_q    <= nxt_s;
						e_q    <= nxt_e;
					end
				end
				S_UP: begin
					node_q <= par;
					cur_q  <= cur_max;
					if (par == NW'(1)) begin
						state_q <= is_req_q ? S_PUSH : S_IDLE;
					end
				end
				S_PUSH: begin
					if (push) begin
						out_bin_q <= res_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item.ready        = (state_q == S_IDLE);
	assign result.valid      = out_valid_q;
	assign result.bin_number = out_bin_q;

endmodule
